// ===== hdl/cdd_pkg.sv =====
// Shared types, constants and calendar tables for the date difference block.
// No dependencies; imported by every module of the block.
package cdd_pkg;

    localparam int unsigned MAX_YEAR = 9999;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DN_W    = 23;
    localparam int unsigned DIFF_W  = 23;
    localparam int unsigned DBM_W   = 9;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**14
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic signed [DIFF_W:0] DIFF_MAX = 24'sd4194303;
    localparam logic signed [DIFF_W:0] DIFF_MIN = -24'sd4194304;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_FIRST_INVALID  = 2'd1,
        ST_SECOND_INVALID = 2'd2,
        ST_SECOND_EARLIER = 2'd3
    } status_t;

    // Load enables of the three lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } cdd_stage_en_t;

    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/cdd_day_number.sv =====
// One date lane: checks a date and forms its day number over three stages.
// Depends on cdd_pkg.
module cdd_day_number (
    input  logic                           clk,
    input  cdd_pkg::cdd_stage_en_t         en,
    input  logic [cdd_pkg::DAY_W-1:0]      day,
    input  logic [cdd_pkg::MONTH_W-1:0]    month,
    input  logic [cdd_pkg::YEAR_W-1:0]     year,
    output logic [cdd_pkg::DN_W-1:0]       day_number,
    output logic                           date_ok
);
    import cdd_pkg::*;

    localparam int unsigned PY_W = YEAR_W + 13;
    localparam int unsigned P4_W = YEAR_W - 2 + 13;

    // stage 1: reciprocal multiplies for the divisions by 100 and 400
    logic [YEAR_W-1:0]  p_next;
    logic [PY_W-1:0]    prod_y;
    logic [PY_W-1:0]    prod_p;
    logic [P4_W-1:0]    prod_p4;
    logic [DAY_W-1:0]   d1_reg;
    logic [MONTH_W-1:0] m1_reg;
    logic [YEAR_W-1:0]  y1_reg;
    logic [YEAR_W-1:0]  p1_reg;
    logic [7:0]         qy_reg;
    logic [7:0]         qp100_reg;
    logic [5:0]         qp400_reg;
    logic               mok_reg;
    logic               yok_reg;

    assign p_next  = year - YEAR_W'(1);
    assign prod_y  = PY_W'(year) * PY_W'(RECIP_100);
    assign prod_p  = PY_W'(p_next) * PY_W'(RECIP_100);
    assign prod_p4 = P4_W'(p_next[YEAR_W-1:2]) * P4_W'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            d1_reg    <= day;
            m1_reg    <= month;
            y1_reg    <= year;
            p1_reg    <= p_next;
            qy_reg    <= prod_y[RECIP_SHIFT +: 8];
            qp100_reg <= prod_p[RECIP_SHIFT +: 8];
            qp400_reg <= prod_p4[RECIP_SHIFT +: 6];
            mok_reg   <= (month >= M_JAN) && (month <= M_DEC);
            yok_reg   <= (year != '0) && (year <= YEAR_W'(MAX_YEAR));
        end
    end

    // stage 2: leap rule, validity, year part of the day number
    logic [YEAR_W:0]    hundred;
    logic               div100;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [DN_W-1:0]    partial_next;
    logic [DBM_W-1:0]   extra_next;
    logic [DN_W-1:0]    partial_reg;
    logic [DBM_W-1:0]   extra_reg;
    logic [DAY_W-1:0]   d2_reg;
    logic               ok2_reg;

    assign hundred = (YEAR_W+1)'(qy_reg) * (YEAR_W+1)'(100);
    assign div100  = ({1'b0, y1_reg} == hundred);
    assign leap    = (y1_reg[1:0] == 2'b00) && (!div100 || (qy_reg[1:0] == 2'b00));
    assign len     = month_length(m1_reg, leap);

    assign partial_next = DN_W'(p1_reg) * DN_W'(365) + DN_W'(p1_reg[YEAR_W-1:2])
                        - DN_W'(qp100_reg) + DN_W'(qp400_reg);
    assign extra_next   = days_before_month(m1_reg)
                        + DBM_W'((m1_reg > M_FEB) && leap);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            partial_reg <= partial_next;
            extra_reg   <= extra_next;
            d2_reg      <= d1_reg;
            ok2_reg     <= mok_reg && yok_reg && (d1_reg != '0) && (d1_reg <= len);
        end
    end

    // stage 3: add month offset and day
    logic [DN_W-1:0] dn_reg;
    logic            ok3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dn_reg  <= partial_reg + DN_W'(extra_reg) + DN_W'(d2_reg);
            ok3_reg <= ok2_reg;
        end
    end

    assign day_number = dn_reg;
    assign date_ok    = ok3_reg;

endmodule

// ===== hdl/calendar_date_difference.sv =====
// Top level of the calendar date difference block: two date lanes and the result stage.
// Depends on cdd_pkg and cdd_day_number.
// An accepted request passes the lane stages and the result stage on its way to the master side.
// Throughput: one request per cycle while the output is not stalled; each stage loads when it is empty or its
// successor loads, so bubbles close up and a stalled output holds only the tail.
// Reset (rst_n low, asynchronous) clears the four stage valid bits; data registers
// keep whatever they hold.
module calendar_date_difference (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] day_first, [8:5] month_first, [22:9] year_first,
    // [27:23] day_second, [31:28] month_second, [45:32] year_second, [47:46] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [24:2] day_difference (signed), [31:25] zero
    output logic [31:0] m_axis_tdata
);
    import cdd_pkg::*;

    // Unpack the request
    logic [DAY_W-1:0]   day_first;
    logic [MONTH_W-1:0] month_first;
    logic [YEAR_W-1:0]  year_first;
    logic [DAY_W-1:0]   day_second;
    logic [MONTH_W-1:0] month_second;
    logic [YEAR_W-1:0]  year_second;

    assign day_first    = s_axis_tdata[4:0];
    assign month_first  = s_axis_tdata[8:5];
    assign year_first   = s_axis_tdata[22:9];
    assign day_second   = s_axis_tdata[27:23];
    assign month_second = s_axis_tdata[31:28];
    assign year_second  = s_axis_tdata[45:32];

    // Stage valid bits and load enables; a stage loads when it is empty
    // or its content moves on in the same cycle.
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          en4;
    cdd_stage_en_t en;

    assign en4   = !v4_reg || m_axis_tready;
    assign en.s3 = !v3_reg || en4;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign s_axis_tready = en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Day numbers of both dates, three stages each
    logic [DN_W-1:0] dn_first;
    logic [DN_W-1:0] dn_second;
    logic            ok_first;
    logic            ok_second;

    cdd_day_number u_first (
        .clk        (clk),
        .en         (en),
        .day        (day_first),
        .month      (month_first),
        .year       (year_first),
        .day_number (dn_first),
        .date_ok    (ok_first)
    );

    cdd_day_number u_second (
        .clk        (clk),
        .en         (en),
        .day        (day_second),
        .month      (month_second),
        .year       (year_second),
        .day_number (dn_second),
        .date_ok    (ok_second)
    );

    // Stage 4: subtract, pick the status, clamp to the output width
    logic signed [DIFF_W:0]   diff_full;
    logic signed [DIFF_W:0]   diff_sat;
    logic        [DIFF_W-1:0] diff_next;
    status_t                  status_next;
    status_t                  status_reg;
    logic        [DIFF_W-1:0] diff_reg;

    assign diff_full = $signed({1'b0, dn_second}) - $signed({1'b0, dn_first});

    always_comb
    begin
        priority if (diff_full > DIFF_MAX)
        begin
            diff_sat = DIFF_MAX;
        end
        else if (diff_full < DIFF_MIN)
        begin
            diff_sat = DIFF_MIN;
        end
        else
        begin
            diff_sat = diff_full;
        end
    end

    // The first date is checked first; any invalid date zeroes the difference.
    always_comb
    begin
        priority if (!ok_first)
        begin
            status_next = ST_FIRST_INVALID;
            diff_next   = '0;
        end
        else if (!ok_second)
        begin
            status_next = ST_SECOND_INVALID;
            diff_next   = '0;
        end
        else
        begin
            status_next = diff_full[DIFF_W] ? ST_SECOND_EARLIER : ST_OK;
            diff_next   = diff_sat[DIFF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            status_reg <= status_next;
            diff_reg   <= diff_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {7'b0, diff_reg, status_reg};

endmodule

// ===== hdl/cdd_checker.sv =====
// Port-level checks for calendar_date_difference, attached by the bind below.
// Depends on cdd_pkg.
module cdd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);
    import cdd_pkg::*;

    logic [1:0]        st;
    logic [DIFF_W-1:0] diff;

    assign st   = m_axis_tdata[1:0];
    assign diff = m_axis_tdata[2 +: DIFF_W];

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // An invalid date always reports a zero difference
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == ST_FIRST_INVALID || st == ST_SECOND_INVALID)
        |-> diff == '0)
        else $error("nonzero difference with an invalid date");

    // Sign of the difference agrees with the status
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == ST_OK || st == ST_SECOND_EARLIER)
        |-> diff[DIFF_W-1] == (st == ST_SECOND_EARLIER))
        else $error("difference sign disagrees with status");

    // A result out of an empty pipeline comes from a request accepted earlier at the input
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
        else $error("result without a matching request");

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (.*);
